// File: src/lsepg_pkg.sv
package lsepg_pkg;

    localparam int MAX_LEDS  = 1024;
    localparam int CNT_W     = 11;
    localparam int IDX_W     = 10;
    localparam int COL_W     = 8;
    localparam int MODE_W    = 3;
    localparam int CFG_AW    = 3;
    localparam int POS_W     = CNT_W + 1;
    localparam int HUE_W     = 9;
    localparam int BIDX_W    = 7;
    localparam int PROD_W    = 2 * COL_W;
    localparam int DIV_DW    = 19;
    localparam int DIV_VW    = CNT_W;
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 3 * COL_W;

    localparam logic [MODE_W-1:0] MODE_INACTIVE = 3'd0;
    localparam logic [MODE_W-1:0] MODE_RAINBOW  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_RUNNING  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_BREATHE  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_WAVE     = 3'd4;

    localparam logic [CFG_AW-1:0] REG_EFFECT_MODE = 3'd0;
    localparam logic [CFG_AW-1:0] REG_LED_COUNT   = 3'd1;
    localparam logic [CFG_AW-1:0] REG_BASE_RED    = 3'd2;
    localparam logic [CFG_AW-1:0] REG_BASE_GREEN  = 3'd3;
    localparam logic [CFG_AW-1:0] REG_BASE_BLUE   = 3'd4;

    localparam logic [COL_W-1:0] SAT_RAINBOW = 8'd255;
    localparam logic [COL_W-1:0] SAT_WAVE    = 8'd200;

    typedef struct packed {
        logic [HUE_W-1:0]  t3;
        logic [HUE_W-1:0]  t4;
        logic [POS_W-1:0]  pos;
        logic [BIDX_W-1:0] bidx;
    } frame_t;

    typedef struct packed {
        logic              done;
        logic [DIV_DW-1:0] quo;
        logic [DIV_VW-1:0] rem;
    } div_res_t;

    typedef struct packed {
        logic                    done;
        logic [2:0][PROD_W-1:0] prod;
    } mul_res_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIV_H,
        ST_HUE,
        ST_DIV_X,
        ST_MUL,
        ST_FIN
    } state_t;

    localparam logic [COL_W-1:0] BREATHE_TABLE [0:119] = '{
        8'd127, 8'd134, 8'd140, 8'd147, 8'd154, 8'd160, 8'd166, 8'd173, 8'd179, 8'd185,
        8'd191, 8'd196, 8'd202, 8'd207, 8'd212, 8'd217, 8'd222, 8'd226, 8'd230, 8'd234,
        8'd237, 8'd241, 8'd243, 8'd246, 8'd248, 8'd250, 8'd252, 8'd253, 8'd254, 8'd254,
        8'd255, 8'd254, 8'd254, 8'd253, 8'd252, 8'd250, 8'd248, 8'd246, 8'd243, 8'd241,
        8'd237, 8'd234, 8'd230, 8'd226, 8'd222, 8'd217, 8'd212, 8'd207, 8'd202, 8'd196,
        8'd191, 8'd185, 8'd179, 8'd173, 8'd166, 8'd160, 8'd154, 8'd147, 8'd140, 8'd134,
        8'd127, 8'd120, 8'd114, 8'd107, 8'd100, 8'd94,  8'd88,  8'd81,  8'd75,  8'd69,
        8'd63,  8'd58,  8'd52,  8'd47,  8'd42,  8'd37,  8'd32,  8'd28,  8'd24,  8'd20,
        8'd17,  8'd13,  8'd11,  8'd8,   8'd6,   8'd4,   8'd2,   8'd1,   8'd0,   8'd0,
        8'd0,   8'd0,   8'd0,   8'd1,   8'd2,   8'd4,   8'd6,   8'd8,   8'd11,  8'd13,
        8'd17,  8'd20,  8'd24,  8'd28,  8'd32,  8'd37,  8'd42,  8'd47,  8'd52,  8'd58,
        8'd63,  8'd69,  8'd75,  8'd81,  8'd88,  8'd94,  8'd100, 8'd107, 8'd114, 8'd120
    };

endpackage

// File: src/lsepg_frame.sv
module lsepg_frame (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        clear,
    input  logic                        advance,
    input  logic [lsepg_pkg::CNT_W-1:0] n_eff,
    output lsepg_pkg::frame_t           frm
);
    import lsepg_pkg::*;

    logic [31:0]        f3_reg, f3_next;
    logic [31:0]        f4_reg, f4_next;
    logic [HUE_W-1:0]   t3_reg, t3_next;
    logic [HUE_W-1:0]   t4_reg, t4_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [BIDX_W-1:0]  bidx_reg, bidx_next;
    logic [32:0]        inc3, inc4;
    logic [HUE_W:0]     s3, s4, r3, r4;
    logic [POS_W-1:0]   pos_last;
    logic               wrap;

    always_comb begin
        inc3     = {1'b0, f3_reg} + 33'd3;
        inc4     = {1'b0, f4_reg} + 33'd4;
        // frame counter itself wraps when 3f hits 2^32 - 3
        wrap     = (f3_reg == 32'hFFFF_FFFD);
        // 2^32 mod 360 is 256, so a carry adds 104 mod 360
        s3       = {1'b0, t3_reg} + 10'd3 + (inc3[32] ? 10'd104 : 10'd0);
        s4       = {1'b0, t4_reg} + 10'd4 + (inc4[32] ? 10'd104 : 10'd0);
        r3       = (s3 >= 10'd360) ? s3 - 10'd360 : s3;
        r4       = (s4 >= 10'd360) ? s4 - 10'd360 : s4;
        pos_last = POS_W'(n_eff) + POS_W'(9);

        f3_next   = f3_reg;
        f4_next   = f4_reg;
        t3_next   = t3_reg;
        t4_next   = t4_reg;
        pos_next  = pos_reg;
        bidx_next = bidx_reg;
        if (clear) begin
            f3_next   = '0;
            f4_next   = '0;
            t3_next   = '0;
            t4_next   = '0;
            pos_next  = '0;
            bidx_next = '0;
        end else if (advance) begin
            f3_next   = inc3[31:0];
            f4_next   = inc4[31:0];
            t3_next   = r3[HUE_W-1:0];
            t4_next   = r4[HUE_W-1:0];
            pos_next  = (wrap || pos_reg == pos_last) ? '0 : pos_reg + 1'b1;
            bidx_next = (wrap || bidx_reg == BIDX_W'(119)) ? '0 : bidx_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f3_reg   <= '0;
            f4_reg   <= '0;
            t3_reg   <= '0;
            t4_reg   <= '0;
            pos_reg  <= '0;
            bidx_reg <= '0;
        end else begin
            f3_reg   <= f3_next;
            f4_reg   <= f4_next;
            t3_reg   <= t3_next;
            t4_reg   <= t4_next;
            pos_reg  <= pos_next;
            bidx_reg <= bidx_next;
        end
    end

    assign frm.t3   = t3_reg;
    assign frm.t4   = t4_reg;
    assign frm.pos  = pos_reg;
    assign frm.bidx = bidx_reg;

endmodule

// File: src/lsepg_div.sv
module lsepg_div (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [lsepg_pkg::DIV_DW-1:0] dividend,
    input  logic [lsepg_pkg::DIV_VW-1:0] divisor,
    output lsepg_pkg::div_res_t          res
);
    import lsepg_pkg::*;

    localparam int CNT_BITS = $clog2(DIV_DW + 1);

    logic [DIV_DW-1:0]   dd_reg, dd_next;
    logic [DIV_VW-1:0]   rem_reg, rem_next;
    logic [DIV_VW-1:0]   dvs_reg, dvs_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                run_reg, run_next;
    logic                done_reg, done_next;
    logic [DIV_VW:0]     trial, diff;

    // restoring division, one quotient bit per cycle
    always_comb begin
        trial     = {rem_reg, dd_reg[DIV_DW-1]};
        diff      = trial - {1'b0, dvs_reg};
        dd_next   = dd_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start) begin
            dd_next  = dividend;
            rem_next = '0;
            dvs_next = divisor;
            cnt_next = CNT_BITS'(DIV_DW);
            run_next = 1'b1;
        end else if (run_reg) begin
            if (trial >= {1'b0, dvs_reg}) begin
                rem_next = diff[DIV_VW-1:0];
                dd_next  = {dd_reg[DIV_DW-2:0], 1'b1};
            end else begin
                rem_next = trial[DIV_VW-1:0];
                dd_next  = {dd_reg[DIV_DW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_BITS'(1)) begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        dd_reg  <= dd_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign res.done = done_reg;
    assign res.quo  = dd_reg;
    assign res.rem  = rem_reg;

endmodule

// File: src/lsepg_smul.sv
module lsepg_smul (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              start,
    input  logic [lsepg_pkg::COL_W-1:0]       br,
    input  logic [2:0][lsepg_pkg::COL_W-1:0]  base,
    output lsepg_pkg::mul_res_t               res
);
    import lsepg_pkg::*;

    localparam int CNT_BITS = $clog2(COL_W + 1);

    logic [2:0][PROD_W-1:0] p_reg, p_next;
    logic [2:0][COL_W:0]    sum;
    logic [CNT_BITS-1:0]    cnt_reg, cnt_next;
    logic                   run_reg, run_next;
    logic                   done_reg, done_next;

    // shift-add, one multiplier bit per cycle on all three channels
    always_comb begin
        p_next    = p_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        for (int ch = 0; ch < 3; ch++) begin
            sum[ch] = {1'b0, p_reg[ch][PROD_W-1:COL_W]}
                    + (p_reg[ch][0] ? {1'b0, base[ch]} : '0);
        end
        if (start) begin
            for (int ch = 0; ch < 3; ch++) begin
                p_next[ch] = {{COL_W{1'b0}}, br};
            end
            cnt_next = CNT_BITS'(COL_W);
            run_next = 1'b1;
        end else if (run_reg) begin
            for (int ch = 0; ch < 3; ch++) begin
                p_next[ch] = {sum[ch], p_reg[ch][COL_W-1:1]};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_BITS'(1)) begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        p_reg <= p_next;
    end

    assign res.done = done_reg;
    assign res.prod = p_reg;

endmodule

// File: src/led_strip_effect_pixel_generator_top.sv
// LED strip effect pixel generator. Each request on the s_ side asks for the colour of one
// pixel; in an active mode a set s_tuser (frame start) first advances the frame counter, and
// a write to any of the five defined registers clears it. A request in an inactive or
// unknown mode, with a zero count or for an index at or beyond the count yields no result.
// Rainbow and wave pixels take two passes of the shared 19-step bit-serial divider (hue
// position, then the HSV ramp). Running-dot and breathe pixels take one pass of the 8-step
// bit-serial multiplier that scales the base colour. One request is in work at a time; a
// finished result waits in the output register while the next request is taken.
module led_strip_effect_pixel_generator_top (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [lsepg_pkg::S_TDATA_W-1:0] s_tdata,   // pixel_index, zero fill
    input  logic                            s_tuser,   // frame_start
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [lsepg_pkg::M_TDATA_W-1:0] m_tdata,   // red, green, blue
    output logic                            m_tlast,
    input  logic                            cfg_wr_en,
    input  logic [lsepg_pkg::CFG_AW-1:0]    cfg_index,
    input  logic [lsepg_pkg::CNT_W-1:0]     cfg_wdata
);
    import lsepg_pkg::*;

    state_t                 state_reg, state_next;
    logic [MODE_W-1:0]      mode_reg, mode_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [2:0][COL_W-1:0]  base_reg, base_next;
    logic [IDX_W-1:0]       idx_reg, idx_next;
    logic                   last_reg, last_next;
    logic [HUE_W-1:0]       hue_reg, hue_next;
    logic [2:0][COL_W-1:0]  res_reg, res_next;
    logic                   m_valid_reg, m_valid_next;
    logic [M_TDATA_W-1:0]   m_data_reg, m_data_next;
    logic                   m_last_reg, m_last_next;

    logic                   cfg_hit;
    logic [CNT_W-1:0]       n_eff;
    logic                   active, accept, advance, in_range;
    logic [IDX_W-1:0]       pix;
    frame_t                 frm;
    div_res_t               div_res;
    mul_res_t               mul_res;
    logic                   div_start, mul_start;
    logic [DIV_DW-1:0]      div_dividend;
    logic [DIV_VW-1:0]      div_divisor;
    logic [COL_W-1:0]       mul_br;
    logic [HUE_W:0]         hsum, hred;
    logic [HUE_W-1:0]       hm;
    logic [5:0]             dd, kk;
    logic [COL_W-1:0]       sat, mm, xm;
    logic [13:0]            ck;
    logic [POS_W-1:0]       dot_gap;

    function automatic logic [COL_W-1:0] div255(input logic [PROD_W-1:0] x);
        logic [PROD_W-1:0] s;
        s = x + {{COL_W{1'b0}}, x[PROD_W-1:COL_W]} + PROD_W'(1);
        return s[PROD_W-1:COL_W];
    endfunction

    // register writes
    always_comb begin
        cfg_hit    = 1'b0;
        mode_next  = mode_reg;
        count_next = count_reg;
        base_next  = base_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_EFFECT_MODE: begin
                    mode_next = cfg_wdata[MODE_W-1:0];
                    cfg_hit   = 1'b1;
                end
                REG_LED_COUNT: begin
                    count_next = cfg_wdata;
                    cfg_hit    = 1'b1;
                end
                REG_BASE_RED: begin
                    base_next[0] = cfg_wdata[COL_W-1:0];
                    cfg_hit      = 1'b1;
                end
                REG_BASE_GREEN: begin
                    base_next[1] = cfg_wdata[COL_W-1:0];
                    cfg_hit      = 1'b1;
                end
                REG_BASE_BLUE: begin
                    base_next[2] = cfg_wdata[COL_W-1:0];
                    cfg_hit      = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    assign n_eff    = (32'(count_reg) > 32'(MAX_LEDS)) ? CNT_W'(MAX_LEDS) : count_reg;
    assign active   = (mode_reg >= MODE_RAINBOW) && (mode_reg <= MODE_WAVE) && (n_eff != '0);
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign advance  = accept && active && s_tuser;
    assign pix      = s_tdata[IDX_W-1:0];
    assign in_range = ({1'b0, pix} < n_eff);

    lsepg_frame u_frame (
        .aclk    (aclk),
        .aresetn (aresetn),
        .clear   (cfg_hit),
        .advance (advance),
        .n_eff   (n_eff),
        .frm     (frm)
    );

    lsepg_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .res      (div_res)
    );

    lsepg_smul u_smul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .br      (mul_br),
        .base    (base_reg),
        .res     (mul_res)
    );

    // hue and hsv helpers
    always_comb begin
        sat  = (mode_reg == MODE_RAINBOW) ? SAT_RAINBOW : SAT_WAVE;
        mm   = 8'd255 - sat;
        hsum = {1'b0, div_res.quo[HUE_W-1:0]} + {1'b0, frm.t3};
        hred = (hsum >= 10'd360) ? hsum - 10'd360 : hsum;
        if (hue_reg < 9'd120) begin
            hm = hue_reg;
        end else if (hue_reg < 9'd240) begin
            hm = hue_reg - 9'd120;
        end else begin
            hm = hue_reg - 9'd240;
        end
        dd   = (hm >= 9'd60) ? 6'(hm - 9'd60) : 6'(9'd60 - hm);
        kk   = 6'd60 - dd;
        ck   = 14'(sat) * 14'(kk);
        xm   = div_res.quo[COL_W-1:0] + mm;
        dot_gap = (POS_W'(idx_reg) >= frm.pos) ? POS_W'(idx_reg) - frm.pos
                                               : frm.pos - POS_W'(idx_reg);
    end

    // sequencer
    always_comb begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        last_next    = last_reg;
        hue_next     = hue_reg;
        res_next     = res_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        m_last_next  = m_last_reg;
        div_start    = 1'b0;
        mul_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = n_eff;
        mul_br       = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && active && in_range) begin
                    idx_next   = pix;
                    last_next  = ({1'b0, pix} == n_eff - 1'b1);
                    state_next = ST_PREP;
                end
            end
            ST_PREP: begin
                unique case (mode_reg)
                    MODE_RAINBOW: begin
                        div_start    = 1'b1;
                        div_dividend = DIV_DW'({idx_reg, 8'd0}) + DIV_DW'({idx_reg, 6'd0})
                                     + DIV_DW'({idx_reg, 5'd0}) + DIV_DW'({idx_reg, 3'd0});
                        div_divisor  = n_eff;
                        state_next   = ST_DIV_H;
                    end
                    MODE_WAVE: begin
                        div_start    = 1'b1;
                        div_dividend = DIV_DW'({idx_reg, 2'd0}) + DIV_DW'(idx_reg)
                                     + DIV_DW'(frm.t4);
                        div_divisor  = DIV_VW'(360);
                        state_next   = ST_DIV_H;
                    end
                    MODE_RUNNING: begin
                        mul_start  = 1'b1;
                        mul_br     = (dot_gap < POS_W'(5))
                                   ? 8'd255 - 8'd51 * {5'd0, dot_gap[2:0]} : 8'd0;
                        state_next = ST_MUL;
                    end
                    MODE_BREATHE: begin
                        mul_start  = 1'b1;
                        mul_br     = BREATHE_TABLE[frm.bidx];
                        state_next = ST_MUL;
                    end
                    default: begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_DIV_H: begin
                if (div_res.done) begin
                    hue_next   = (mode_reg == MODE_RAINBOW) ? hred[HUE_W-1:0]
                                                            : div_res.rem[HUE_W-1:0];
                    state_next = ST_HUE;
                end
            end
            ST_HUE: begin
                div_start    = 1'b1;
                div_dividend = DIV_DW'(ck);
                div_divisor  = DIV_VW'(60);
                state_next   = ST_DIV_X;
            end
            ST_DIV_X: begin
                div_divisor = DIV_VW'(60);
                if (div_res.done) begin
                    if (hue_reg < 9'd60) begin
                        res_next = {mm, xm, 8'd255};
                    end else if (hue_reg < 9'd120) begin
                        res_next = {mm, 8'd255, xm};
                    end else if (hue_reg < 9'd180) begin
                        res_next = {xm, 8'd255, mm};
                    end else if (hue_reg < 9'd240) begin
                        res_next = {8'd255, xm, mm};
                    end else if (hue_reg < 9'd300) begin
                        res_next = {8'd255, mm, xm};
                    end else begin
                        res_next = {xm, mm, 8'd255};
                    end
                    state_next = ST_FIN;
                end
            end
            ST_MUL: begin
                if (mul_res.done) begin
                    for (int ch = 0; ch < 3; ch++) begin
                        res_next[ch] = div255(mul_res.prod[ch]);
                    end
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    m_last_next  = last_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            mode_reg    <= MODE_INACTIVE;
            count_reg   <= '0;
            base_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            mode_reg    <= mode_next;
            count_reg   <= count_next;
            base_reg    <= base_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg    <= idx_next;
        last_reg   <= last_next;
        hue_reg    <= hue_next;
        res_reg    <= res_next;
        m_data_reg <= m_data_next;
        m_last_reg <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

    a_div_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        div_res.done |-> (state_reg == ST_DIV_H || state_reg == ST_DIV_X))
        else $error("divider finished outside a divide step");

    a_mul_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_res.done |-> (state_reg == ST_MUL))
        else $error("multiplier finished outside the scale step");

    a_index_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_PREP) |-> ({1'b0, idx_reg} < n_eff))
        else $error("pixel in work lies beyond the strip");

    a_pos_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        frm.pos < (POS_W'(n_eff) + POS_W'(10)))
        else $error("running dot position out of range");

    a_fin_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FIN && (!m_valid_reg || m_tready))
        |=> (m_valid_reg && state_reg == ST_IDLE))
        else $error("finished pixel not moved to the output");

endmodule

// File: test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import lsepg_pkg::*;

    localparam int          CYCLE_LIMIT   = 400000;
    localparam int          SETTLE_CYCLES = 60;
    localparam int          RX_HOLD       = 300;
    localparam int          RAND_REQUESTS = 400;
    localparam logic [2:0]  REG_SPARE     = 3'd7;
    localparam logic [2:0]  MODE_UNKNOWN  = 3'd7;

    localparam logic [7:0] BREATH_LUT [0:119] = '{
        8'd127, 8'd134, 8'd140, 8'd147, 8'd154, 8'd160, 8'd166, 8'd173, 8'd179, 8'd185,
        8'd191, 8'd196, 8'd202, 8'd207, 8'd212, 8'd217, 8'd222, 8'd226, 8'd230, 8'd234,
        8'd237, 8'd241, 8'd243, 8'd246, 8'd248, 8'd250, 8'd252, 8'd253, 8'd254, 8'd254,
        8'd255, 8'd254, 8'd254, 8'd253, 8'd252, 8'd250, 8'd248, 8'd246, 8'd243, 8'd241,
        8'd237, 8'd234, 8'd230, 8'd226, 8'd222, 8'd217, 8'd212, 8'd207, 8'd202, 8'd196,
        8'd191, 8'd185, 8'd179, 8'd173, 8'd166, 8'd160, 8'd154, 8'd147, 8'd140, 8'd134,
        8'd127, 8'd120, 8'd114, 8'd107, 8'd100, 8'd94,  8'd88,  8'd81,  8'd75,  8'd69,
        8'd63,  8'd58,  8'd52,  8'd47,  8'd42,  8'd37,  8'd32,  8'd28,  8'd24,  8'd20,
        8'd17,  8'd13,  8'd11,  8'd8,   8'd6,   8'd4,   8'd2,   8'd1,   8'd0,   8'd0,
        8'd0,   8'd0,   8'd0,   8'd1,   8'd2,   8'd4,   8'd6,   8'd8,   8'd11,  8'd13,
        8'd17,  8'd20,  8'd24,  8'd28,  8'd32,  8'd37,  8'd42,  8'd47,  8'd52,  8'd58,
        8'd63,  8'd69,  8'd75,  8'd81,  8'd88,  8'd94,  8'd100, 8'd107, 8'd114, 8'd120
    };

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last;
    } pixel_t;

    typedef enum bit {ROW_WRITE, ROW_REQ} row_kind_t;
    typedef enum bit [1:0] {CHK_MODEL, CHK_NONE, CHK_PIXEL} chk_t;

    typedef struct {
        row_kind_t   kind;
        logic [2:0]  reg_idx;
        logic [10:0] wdata;
        logic [9:0]  idx;
        bit          fs;
        chk_t        chk;
        pixel_t      px;
    } row_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;
    logic                 cfg_wr_en;
    logic [CFG_AW-1:0]    cfg_index;
    logic [CNT_W-1:0]     cfg_wdata;

    // strip state as the block should hold it
    logic [2:0]  fx_mode;
    logic [10:0] led_cnt;
    logic [7:0]  base_r;
    logic [7:0]  base_g;
    logic [7:0]  base_b;
    logic [31:0] frame_cnt;

    pixel_t      pending_colors [$];
    row_t        dir_rows [$];
    chk_t        req_chk;
    pixel_t      req_px;
    pixel_t      model_px;
    bit          model_has;
    pixel_t      want;
    int          mismatches;
    int unsigned cycle_cnt;
    bit          rx_hold_req;
    bit          quiet;
    bit          dirty;

    led_strip_effect_pixel_generator_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        cycle_cnt = 0;
        wait (cycle_cnt >= CYCLE_LIMIT);
        $display("Some tests failed");
        $finish;
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
    end

    function automatic pixel_t hsv_color(input int hue, input int sat);
        pixel_t px;
        int h, c, m, hm, d, x;
        h  = hue % 360;
        c  = sat;
        m  = 255 - c;
        hm = h % 120;
        d  = (hm >= 60) ? hm - 60 : 60 - hm;
        x  = c * (60 - d) / 60;
        case (h / 60)
            0: px = {8'(c), 8'(x), 8'(0), 1'b0};
            1: px = {8'(x), 8'(c), 8'(0), 1'b0};
            2: px = {8'(0), 8'(c), 8'(x), 1'b0};
            3: px = {8'(0), 8'(x), 8'(c), 1'b0};
            4: px = {8'(x), 8'(0), 8'(c), 1'b0};
            default: px = {8'(c), 8'(0), 8'(x), 1'b0};
        endcase
        px.red   = px.red + m;
        px.green = px.green + m;
        px.blue  = px.blue + m;
        return px;
    endfunction

    function automatic pixel_t scale_base(input int br);
        pixel_t px;
        px.red   = 8'(int'(base_r) * br / 255);
        px.green = 8'(int'(base_g) * br / 255);
        px.blue  = 8'(int'(base_b) * br / 255);
        px.last  = 1'b0;
        return px;
    endfunction

    task automatic predict_pixel_color(input logic [9:0] idx, input bit fs,
                                       output bit has, output pixel_t px);
        int          n;
        int          hue;
        int          pos;
        int          gap;
        logic [31:0] wrapped;
        has = 1'b0;
        px  = '0;
        n   = (led_cnt > MAX_LEDS) ? MAX_LEDS : int'(led_cnt);
        if (fx_mode < MODE_RAINBOW || fx_mode > MODE_WAVE || n == 0) return;
        if (fs) frame_cnt = frame_cnt + 1;
        if (int'(idx) >= n) return;
        has = 1'b1;
        case (fx_mode)
            MODE_RAINBOW: begin
                wrapped = frame_cnt * 3;
                hue = (int'(idx) * 360 / n + int'(wrapped % 360)) % 360;
                px = hsv_color(hue, SAT_RAINBOW);
            end
            MODE_RUNNING: begin
                wrapped = frame_cnt % (n + 10);
                pos = int'(wrapped);
                gap = (int'(idx) >= pos) ? int'(idx) - pos : pos - int'(idx);
                if (gap < 5) px = scale_base(255 - 51 * gap);
            end
            MODE_BREATHE: begin
                px = scale_base(BREATH_LUT[frame_cnt % 120]);
            end
            default: begin
                wrapped = frame_cnt * 4;
                hue = (int'(idx) * 5 + int'(wrapped % 360)) % 360;
                px = hsv_color(hue, SAT_WAVE);
            end
        endcase
        px.last = (int'(idx) == n - 1);
    endtask

    task automatic report_mismatch(input string what, input int got, input int exp_val);
        $display("mismatch: %s got %0d want %0d at %0t", what, got, exp_val, $time);
        mismatches++;
    endtask

    // request monitor: predict at acceptance
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            predict_pixel_color(s_tdata[IDX_W-1:0], s_tuser, model_has, model_px);
            case (req_chk)
                CHK_NONE: model_has = 1'b0;
                CHK_PIXEL: begin
                    model_has = 1'b1;
                    model_px  = req_px;
                end
                default: ;
            endcase
            if (model_has) pending_colors.push_back(model_px);
        end
    end

    // result monitor
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_colors.size() == 0) begin
                report_mismatch("result with no request pending", 1, 0);
            end else begin
                want = pending_colors.pop_front();
                if (m_tdata[7:0] !== want.red)
                    report_mismatch("red", m_tdata[7:0], want.red);
                if (m_tdata[15:8] !== want.green)
                    report_mismatch("green", m_tdata[15:8], want.green);
                if (m_tdata[23:16] !== want.blue)
                    report_mismatch("blue", m_tdata[23:16], want.blue);
                if (m_tlast !== want.last)
                    report_mismatch("last pixel", m_tlast, want.last);
            end
        end
    end

    // result side ready, with one long hold-off on request
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (rx_hold_req) begin
                m_tready = 1'b0;
                repeat (RX_HOLD - 1) @(negedge aclk);
                rx_hold_req = 1'b0;
            end else begin
                m_tready = quiet || ($urandom_range(99) >= 19);
            end
        end
    end

    function automatic void add_write(input logic [2:0] reg_idx, input logic [10:0] wdata);
        row_t row;
        row = '{ROW_WRITE, reg_idx, wdata, 10'd0, 1'b0, CHK_MODEL, '0};
        dir_rows.push_back(row);
    endfunction

    function automatic void add_req(input logic [9:0] idx, input bit fs, input chk_t chk,
                                    input pixel_t px);
        row_t row;
        row = '{ROW_REQ, 3'd0, 11'd0, idx, fs, chk, px};
        dir_rows.push_back(row);
    endfunction

    task automatic send_request(input logic [9:0] idx, input bit fs, input chk_t chk,
                                input pixel_t px);
        @(negedge aclk);
        if (!quiet && $urandom_range(99) < 19) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {{(S_TDATA_W - IDX_W){1'b0}}, idx};
        s_tuser  = fs;
        req_chk  = chk;
        req_px   = px;
        dirty    = 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // block idle: no request offered, every result back, trailing work done
    task automatic settle();
        if (dirty) begin
            @(negedge aclk);
            s_tvalid = 1'b0;
            while (pending_colors.size() != 0) @(negedge aclk);
            repeat (SETTLE_CYCLES) @(negedge aclk);
            dirty = 1'b0;
        end
    endtask

    task automatic write_reg(input logic [2:0] reg_idx, input logic [10:0] wdata);
        @(negedge aclk);
        cfg_wr_en = 1'b1;
        cfg_index = reg_idx;
        cfg_wdata = wdata;
        case (reg_idx)
            REG_EFFECT_MODE: fx_mode = wdata[2:0];
            REG_LED_COUNT:   led_cnt = wdata;
            REG_BASE_RED:    base_r  = wdata[7:0];
            REG_BASE_GREEN:  base_g  = wdata[7:0];
            REG_BASE_BLUE:   base_b  = wdata[7:0];
            default: ;
        endcase
        if (reg_idx <= REG_BASE_BLUE) frame_cnt = '0;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    initial begin
        int          phase;
        int          frames;
        int          len;
        int          first;
        int          max_len;
        int          n_eff;
        int          live_requests;
        int          pick;
        bit          live;
        logic [2:0]  mode_sel;
        logic [10:0] count_sel;

        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_index   = '0;
        cfg_wdata   = '0;
        req_chk     = CHK_MODEL;
        req_px      = '0;
        mismatches  = 0;
        rx_hold_req = 1'b0;
        quiet       = 1'b0;
        dirty       = 1'b0;
        fx_mode     = MODE_INACTIVE;
        led_cnt     = '0;
        base_r      = '0;
        base_g      = '0;
        base_b      = '0;
        frame_cnt   = '0;

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed rows
        add_req(10'd0, 1'b0, CHK_NONE, '0);
        add_req(10'd1023, 1'b1, CHK_NONE, '0);
        add_write(REG_EFFECT_MODE, 11'(MODE_RAINBOW));
        add_req(10'd0, 1'b1, CHK_NONE, '0);
        add_write(REG_LED_COUNT, 11'd1);
        add_req(10'd0, 1'b0, CHK_PIXEL, {8'd255, 8'd0, 8'd0, 1'b1});
        add_req(10'd1, 1'b1, CHK_NONE, '0);
        add_req(10'd0, 1'b0, CHK_MODEL, '0);
        add_write(REG_LED_COUNT, 11'd2047);
        add_req(10'd1023, 1'b1, CHK_MODEL, '0);
        add_req(10'd0, 1'b1, CHK_MODEL, '0);
        add_write(REG_SPARE, 11'h7ff);
        add_req(10'd512, 1'b0, CHK_MODEL, '0);
        add_write(REG_BASE_RED, 11'd255);
        add_write(REG_BASE_GREEN, 11'd255);
        add_write(REG_BASE_BLUE, 11'd255);
        add_write(REG_EFFECT_MODE, 11'(MODE_BREATHE));
        add_req(10'd0, 1'b0, CHK_PIXEL, {8'd127, 8'd127, 8'd127, 1'b0});
        add_req(10'd1023, 1'b1, CHK_MODEL, '0);
        add_write(REG_EFFECT_MODE, 11'(MODE_RUNNING));
        add_write(REG_BASE_RED, 11'h7ff);
        add_write(REG_BASE_GREEN, 11'h700);
        add_req(10'd0, 1'b0, CHK_PIXEL, {8'd255, 8'd0, 8'd255, 1'b0});
        add_req(10'd4, 1'b0, CHK_MODEL, '0);
        add_req(10'd5, 1'b0, CHK_PIXEL, {8'd0, 8'd0, 8'd0, 1'b0});
        add_write(REG_EFFECT_MODE, 11'(MODE_WAVE));
        add_req(10'd1023, 1'b0, CHK_MODEL, '0);
        add_req(10'd72, 1'b1, CHK_MODEL, '0);
        add_write(REG_EFFECT_MODE, 11'(MODE_UNKNOWN));
        add_req(10'd0, 1'b1, CHK_NONE, '0);
        add_write(REG_LED_COUNT, 11'd0);

        foreach (dir_rows[k]) begin
            if (dir_rows[k].kind == ROW_WRITE) begin
                settle();
                write_reg(dir_rows[k].reg_idx, dir_rows[k].wdata);
            end else begin
                send_request(dir_rows[k].idx, dir_rows[k].fs, dir_rows[k].chk,
                             dir_rows[k].px);
            end
        end

        // random phases: new settings, then frames of requests
        phase = 0;
        live_requests = 0;
        while (live_requests < RAND_REQUESTS) begin
            settle();
            quiet = (phase == 3 || phase == 4);

            pick = $urandom_range(0, 9);
            if (pick < 8)       mode_sel = MODE_RAINBOW + 3'(pick % 4);
            else if (pick == 8) mode_sel = MODE_INACTIVE;
            else                mode_sel = MODE_WAVE + 3'($urandom_range(1, 3));

            pick = $urandom_range(0, 19);
            if (pick < 16)       count_sel = 11'($urandom_range(1, 24));
            else if (pick == 16) count_sel = 11'd0;
            else if (pick == 17) count_sel = 11'd1024;
            else if (pick == 18) count_sel = 11'($urandom_range(1025, 2047));
            else                 count_sel = 11'($urandom_range(25, 1023));

            if (phase == 1) begin
                mode_sel  = MODE_WAVE;
                count_sel = 11'd12;
            end

            write_reg(REG_LED_COUNT, count_sel);
            if ($urandom_range(99) < 70) write_reg(REG_BASE_RED, 11'($urandom_range(0, 2047)));
            if ($urandom_range(99) < 70) write_reg(REG_BASE_GREEN, 11'($urandom_range(0, 2047)));
            if ($urandom_range(99) < 70) write_reg(REG_BASE_BLUE, 11'($urandom_range(0, 2047)));
            write_reg(REG_EFFECT_MODE, 11'(mode_sel));
            if ($urandom_range(99) < 20)
                write_reg(REG_BASE_BLUE + 3'($urandom_range(1, 3)), 11'($urandom_range(0, 2047)));

            if (phase == 1) rx_hold_req = 1'b1;

            n_eff = (count_sel > MAX_LEDS) ? MAX_LEDS : int'(count_sel);
            live  = (mode_sel >= MODE_RAINBOW && mode_sel <= MODE_WAVE && n_eff != 0);
            case (mode_sel)
                MODE_BREATHE: begin
                    max_len = 2;
                    frames  = $urandom_range(20, 130);
                end
                MODE_RUNNING: begin
                    max_len = 4;
                    frames  = (n_eff + 12 > 40) ? 40 : n_eff + 12;
                end
                default: begin
                    max_len = 24;
                    frames  = $urandom_range(2, 5);
                end
            endcase
            if (!live) begin
                max_len = 4;
                frames  = 2;
            end
            len = (live && n_eff < max_len) ? n_eff : max_len;

            repeat (frames) begin
                first = live ? $urandom_range(0, n_eff - len) : 0;
                for (int k = 0; k < len; k++) begin
                    if ($urandom_range(99) < 15)
                        send_request(10'($urandom_range(0, 1023)), $urandom_range(0, 1),
                                     CHK_MODEL, '0);
                    else
                        send_request(10'(first + k), k == 0, CHK_MODEL, '0);
                    if (live) live_requests++;
                end
            end
            phase++;
        end

        settle();
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
